/* src/twrtc_pkg.sv */
// ----------------------------------------------------------------------------
// twrtc_pkg
// Types and constants shared by the three-wire serial master.
// ----------------------------------------------------------------------------
package twrtc_pkg;

  localparam int unsigned BURST_DATA_BYTES_DEF = 7;
  localparam int unsigned STORE_DEPTH          = 7;
  localparam logic [7:0]  CTRL_BYTE            = 8'h00;

  // kind field values: 0 single write, 1 single read, 2 burst write, 3 burst read
  localparam int unsigned KIND_READ_BIT  = 0;
  localparam int unsigned KIND_BURST_BIT = 1;

  localparam logic [2:0] LAST_BIT = 3'd7;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    logic       start_req;
    logic [1:0] kind;
    byte_t      command;
    byte_t      byte_0;
    byte_t      byte_1;
    byte_t      byte_2;
    byte_t      byte_3;
    byte_t      byte_4;
    byte_t      byte_5;
    byte_t      byte_6;
    logic       io_in;
  } in_item_t;

  typedef struct packed {
    logic  chip_enable;
    logic  io_drive;
    logic  io_level;
    logic  clock_pulse;
    logic  read_valid;
    byte_t read_value;
    logic  read_last;
    logic  busy_res;
  } out_item_t;

endpackage

/* src/twrtc_in_if.sv */
// ----------------------------------------------------------------------------
// twrtc_in_if
// Valid/ready channel carrying one bit-slot item into the master.
// ----------------------------------------------------------------------------
interface twrtc_in_if;
  import twrtc_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* src/twrtc_out_if.sv */
// ----------------------------------------------------------------------------
// twrtc_out_if
// Valid/ready channel carrying one bit-slot result out of the master.
// ----------------------------------------------------------------------------
interface twrtc_out_if;
  import twrtc_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* src/three_wire_rtc_serial_master_unit.sv */
// ----------------------------------------------------------------------------
// three_wire_rtc_serial_master_unit
// Three-wire serial master, one bit slot per transfer, LSB first.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one bit slot per transfer: start request, kind, command,
//   the seven write bytes and the sampled data line level. out_o returns one
//   result per slot: enable, drive, level, clock pulse, read byte and busy.
//   A start is taken only while idle; the start slot raises enable without
//   a clock, then 8 command slots, then 8 slots per data byte follow.
//   An input register feeds the slot logic, which loads the result register
//   that drives out_o. Throughput is one slot per cycle while the receiver
//   takes results; the transaction state advances as an item moves from the
//   input register into the result register. When the receiver stalls, the
//   result register holds, the input register fills, and ready on in_i drops
//   until the result is taken. Reset empties both registers and returns the
//   master to idle with all counters and shift registers cleared.
// ----------------------------------------------------------------------------
module three_wire_rtc_serial_master_unit #(
  parameter int unsigned BURST_DATA_BYTES = twrtc_pkg::BURST_DATA_BYTES_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  twrtc_in_if.sink     in_i,
  twrtc_out_if.source  out_o
);
  import twrtc_pkg::*;

  logic      in_vld_q;
  in_item_t  in_item_q;
  logic      res_vld_q;
  out_item_t res_q;
  out_item_t step_res;
  logic      advance;

  assign advance     = in_vld_q && (!res_vld_q || out_o.ready);
  assign in_i.ready  = !in_vld_q || advance;
  assign out_o.valid = res_vld_q;
  assign out_o.data  = res_q;

  twrtc_engine #(
    .BURST_DATA_BYTES(BURST_DATA_BYTES)
  ) u_engine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .item_i  (in_item_q),
    .result_o(step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_vld_q <= in_i.valid;
      end
      if (advance) begin
        res_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_item_q <= in_i.data;
    end
    if (advance) begin
      res_q <= step_res;
    end
  end

endmodule

/* src/twrtc_engine.sv */
// ----------------------------------------------------------------------------
// twrtc_engine
// Transaction state and per-slot logic: command/data shifting, read assembly.
// ----------------------------------------------------------------------------
module twrtc_engine #(
  parameter int unsigned BURST_DATA_BYTES = twrtc_pkg::BURST_DATA_BYTES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  twrtc_pkg::in_item_t  item_i,
  output twrtc_pkg::out_item_t result_o
);
  import twrtc_pkg::*;

  // byte counter reaches burst length + 1; its increment reaches burst length + 2 before wrapping to idle
  localparam int unsigned CW = $clog2(BURST_DATA_BYTES + 3);
  localparam logic [CW-1:0] BURST_TOTAL = CW'(BURST_DATA_BYTES + 1);
  localparam logic [CW-1:0] ONE_BYTE    = CW'(1);

  logic          active_q, active_d;
  logic [1:0]    mode_q, mode_d;
  logic [2:0]    bit_count_q, bit_count_d;
  logic [CW-1:0] byte_count_q, byte_count_d;
  byte_t         shift_out_q, shift_out_d;
  byte_t         shift_in_q, shift_in_d;
  byte_t         store_q [STORE_DEPTH];
  logic          store_we;

  logic          reading;
  logic [CW-1:0] total;
  logic [CW-1:0] byte_next;
  logic [CW-1:0] data_idx;
  byte_t         next_byte;

  assign reading   = mode_q[KIND_READ_BIT] && (byte_count_q != '0);
  assign total     = mode_q[KIND_BURST_BIT] ? BURST_TOTAL : ONE_BYTE;
  assign byte_next = byte_count_q + ONE_BYTE;
  assign data_idx  = byte_next - ONE_BYTE;

  // write data for the byte that follows; control byte closes a burst
  always_comb begin
    next_byte = CTRL_BYTE;
    if (!mode_q[KIND_BURST_BIT]) begin
      next_byte = store_q[0];
    end else begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
        if ((i < BURST_DATA_BYTES) && (data_idx == CW'(i))) begin
          next_byte = store_q[i];
        end
      end
    end
  end

  always_comb begin
    active_d     = active_q;
    mode_d       = mode_q;
    bit_count_d  = bit_count_q;
    byte_count_d = byte_count_q;
    shift_out_d  = shift_out_q;
    shift_in_d   = shift_in_q;
    store_we     = 1'b0;
    result_o     = '0;
    if (!active_q) begin
      if (item_i.start_req) begin
        active_d             = 1'b1;
        mode_d               = item_i.kind;
        bit_count_d          = '0;
        byte_count_d         = '0;
        shift_out_d          = item_i.command;
        shift_in_d           = '0;
        store_we             = 1'b1;
        result_o.chip_enable = 1'b1;
        result_o.busy_res    = 1'b1;
      end
    end else begin
      result_o.chip_enable = 1'b1;
      result_o.busy_res    = 1'b1;
      result_o.clock_pulse = 1'b1;
      if (reading) begin
        shift_in_d[bit_count_q] = shift_in_q[bit_count_q] | item_i.io_in;
      end else begin
        result_o.io_drive = 1'b1;
        result_o.io_level = shift_out_q[0];
        shift_out_d       = {1'b0, shift_out_q[7:1]};
      end
      if (bit_count_q == LAST_BIT) begin
        if (reading) begin
          result_o.read_valid = 1'b1;
          result_o.read_value = shift_in_d;
          result_o.read_last  = (byte_count_q == total);
        end
        bit_count_d = '0;
        shift_in_d  = '0;
        if (byte_next > total) begin
          active_d     = 1'b0;
          byte_count_d = '0;
        end else begin
          byte_count_d = byte_next;
          if (!mode_q[KIND_READ_BIT]) begin
            shift_out_d = next_byte;
          end
        end
      end else begin
        bit_count_d = bit_count_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q     <= 1'b0;
      mode_q       <= '0;
      bit_count_q  <= '0;
      byte_count_q <= '0;
      shift_out_q  <= '0;
      shift_in_q   <= '0;
    end else if (step_i) begin
      active_q     <= active_d;
      mode_q       <= mode_d;
      bit_count_q  <= bit_count_d;
      byte_count_q <= byte_count_d;
      shift_out_q  <= shift_out_d;
      shift_in_q   <= shift_in_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && store_we) begin
      store_q[0] <= item_i.byte_0;
      store_q[1] <= item_i.byte_1;
      store_q[2] <= item_i.byte_2;
      store_q[3] <= item_i.byte_3;
      store_q[4] <= item_i.byte_4;
      store_q[5] <= item_i.byte_5;
      store_q[6] <= item_i.byte_6;
    end
  end

endmodule

/* tb/sv/three_wire_rtc_serial_master_unit_test.sv */
// ----------------------------------------------------------------------------
// three_wire_rtc_serial_master_unit_test
// Drives bit slots into the serial master and checks every slot result
// against a cycle model of the link state. Single and burst reads and writes
// are run with random content, with starts thrown in while busy and with
// random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module three_wire_rtc_serial_master_unit_test;
  import twrtc_pkg::*;

  localparam int unsigned BURST_BYTES = BURST_DATA_BYTES_DEF;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned ITEMS_PER_PHASE = 70;

  typedef enum logic [1:0] {
    SINGLE_WRITE = 2'd0,
    SINGLE_READ  = 2'd1,
    BURST_WRITE  = 2'd2,
    BURST_READ   = 2'd3
  } kind_e;

  typedef enum int {
    IO_RANDOM = 0,
    IO_ONES   = 1,
    IO_ZEROS  = 2
  } io_pattern_e;

  logic clk_i;
  logic rst_ni;

  twrtc_in_if  slot_if ();
  twrtc_out_if res_if ();

  three_wire_rtc_serial_master_unit #(
    .BURST_DATA_BYTES(BURST_BYTES)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (slot_if),
    .out_o (res_if)
  );

  in_item_t  slot_item_q[$];
  out_item_t slot_result_q[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int fail_count = 0;
  int unsigned quiet_cycles = 0;

  // link model state
  logic        link_active = 1'b0;
  logic [1:0]  link_kind = '0;
  logic [2:0]  bit_idx = '0;
  logic [3:0]  byte_idx = '0;
  byte_t       tx_shift = '0;
  byte_t       rx_shift = '0;
  byte_t       wr_bytes [STORE_DEPTH];

  function automatic out_item_t serial_slot_model(input in_item_t slot);
    out_item_t   res;
    logic        reading;
    int unsigned data_total;
    int unsigned d;
    res = '0;
    if (!link_active) begin
      if (slot.start_req) begin
        link_active = 1'b1;
        link_kind   = slot.kind;
        bit_idx     = '0;
        byte_idx    = '0;
        tx_shift    = slot.command;
        rx_shift    = '0;
        wr_bytes[0] = slot.byte_0;
        wr_bytes[1] = slot.byte_1;
        wr_bytes[2] = slot.byte_2;
        wr_bytes[3] = slot.byte_3;
        wr_bytes[4] = slot.byte_4;
        wr_bytes[5] = slot.byte_5;
        wr_bytes[6] = slot.byte_6;
        res.chip_enable = 1'b1;
        res.busy_res    = 1'b1;
      end
    end else begin
      reading    = link_kind[KIND_READ_BIT] && (byte_idx != 0);
      data_total = link_kind[KIND_BURST_BIT] ? BURST_BYTES + 1 : 1;
      res.chip_enable = 1'b1;
      res.busy_res    = 1'b1;
      res.clock_pulse = 1'b1;
      if (reading) begin
        if (slot.io_in) rx_shift[bit_idx] = 1'b1;
      end else begin
        res.io_drive = 1'b1;
        res.io_level = tx_shift[0];
        tx_shift     = tx_shift >> 1;
      end
      if (bit_idx == LAST_BIT) begin
        if (reading) begin
          res.read_valid = 1'b1;
          res.read_value = rx_shift;
          res.read_last  = (byte_idx == data_total);
        end
        bit_idx  = '0;
        byte_idx = byte_idx + 4'd1;
        rx_shift = '0;
        if (byte_idx > data_total) begin
          link_active = 1'b0;
          byte_idx    = '0;
        end else if (!link_kind[KIND_READ_BIT]) begin
          d = byte_idx - 1;
          // burst write ends with the control byte; missing stored bytes go out as zero
          if (!link_kind[KIND_BURST_BIT]) tx_shift = wr_bytes[0];
          else if (d < BURST_BYTES) tx_shift = (d < STORE_DEPTH) ? wr_bytes[d] : 8'h00;
          else tx_shift = CTRL_BYTE;
        end
      end else begin
        bit_idx = bit_idx + 3'd1;
      end
    end
    return res;
  endfunction

  function automatic in_item_t random_slot();
    in_item_t s;
    s.start_req = 1'b0;
    s.kind      = 2'($urandom_range(3));
    s.command   = 8'($urandom_range(255));
    s.byte_0    = 8'($urandom_range(255));
    s.byte_1    = 8'($urandom_range(255));
    s.byte_2    = 8'($urandom_range(255));
    s.byte_3    = 8'($urandom_range(255));
    s.byte_4    = 8'($urandom_range(255));
    s.byte_5    = 8'($urandom_range(255));
    s.byte_6    = 8'($urandom_range(255));
    s.io_in     = 1'($urandom_range(1));
    return s;
  endfunction

  // queues the start slot and every bit slot of one transaction
  function automatic int queue_transaction(input in_item_t head, input int busy_start_pct,
                                           input io_pattern_e io_pattern);
    int       n_body;
    in_item_t s;
    n_body = 8 * (1 + (head.kind[KIND_BURST_BIT] ? BURST_BYTES + 1 : 1));
    head.start_req = 1'b1;
    slot_item_q.push_back(head);
    for (int i = 0; i < n_body; i++) begin
      s = random_slot();
      s.start_req = ($urandom_range(99) < busy_start_pct);
      if (io_pattern == IO_ONES) s.io_in = 1'b1;
      else if (io_pattern == IO_ZEROS) s.io_in = 1'b0;
      slot_item_q.push_back(s);
    end
    return n_body + 1;
  endfunction

  task automatic wait_drained();
    do @(negedge clk_i);
    while (slot_item_q.size() != 0 || slot_if.valid || slot_result_q.size() != 0);
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_if.valid <= 1'b0;
      slot_if.data  <= '0;
    end else begin
      if (slot_if.valid && slot_if.ready) begin
        slot_result_q.push_back(serial_slot_model(slot_if.data));
      end
      if (!slot_if.valid || slot_if.ready) begin
        if (slot_item_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          slot_if.data  <= slot_item_q.pop_front();
          slot_if.valid <= 1'b1;
        end else begin
          slot_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (slot_result_q.size() == 0) begin
          $error("result transfer with nothing outstanding: 0x%0h", res_if.data);
          fail_count++;
        end else begin
          want = slot_result_q.pop_front();
          check_field("chip_enable", want.chip_enable, res_if.data.chip_enable);
          check_field("io_drive", want.io_drive, res_if.data.io_drive);
          check_field("io_level", want.io_level, res_if.data.io_level);
          check_field("clock_pulse", want.clock_pulse, res_if.data.clock_pulse);
          check_field("read_valid", want.read_valid, res_if.data.read_valid);
          check_field("read_value", want.read_value, res_if.data.read_value);
          check_field("read_last", want.read_last, res_if.data.read_last);
          check_field("busy_res", want.busy_res, res_if.data.busy_res);
        end
      end
      res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((slot_if.valid && slot_if.ready) || (res_if.valid && res_if.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("three_wire_rtc_serial_master_unit verification failed");
        $finish;
      end
    end
  end

  initial begin
    int       idle_by_phase [4];
    int       stall_by_phase [4];
    int       added;
    in_item_t hd;
    idle_by_phase  = '{0, 48, 0, 35};
    stall_by_phase = '{0, 0, 48, 35};
    @(posedge rst_ni);

    // directed: idle slot, each kind, extreme values, starts while busy
    hd = random_slot();
    slot_item_q.push_back(hd);
    hd = random_slot();
    hd.kind = SINGLE_WRITE; hd.command = 8'hFF; hd.byte_0 = 8'h00;
    added = queue_transaction(hd, 50, IO_RANDOM);
    hd = random_slot();
    hd.kind = SINGLE_WRITE; hd.command = 8'h00; hd.byte_0 = 8'hFF;
    added = queue_transaction(hd, 0, IO_RANDOM);
    hd = random_slot();
    hd.kind = SINGLE_READ; hd.command = 8'h00;
    added = queue_transaction(hd, 0, IO_ONES);
    hd = random_slot();
    hd.kind = SINGLE_READ; hd.command = 8'hFF;
    added = queue_transaction(hd, 100, IO_ZEROS);
    hd = random_slot();
    hd.kind = BURST_WRITE; hd.command = 8'hA5;
    hd.byte_0 = 8'hFF; hd.byte_1 = 8'h00; hd.byte_2 = 8'hFF; hd.byte_3 = 8'h00;
    hd.byte_4 = 8'hFF; hd.byte_5 = 8'h00; hd.byte_6 = 8'hFF;
    added = queue_transaction(hd, 0, IO_RANDOM);
    hd = random_slot();
    hd.kind = BURST_READ; hd.command = 8'h5A;
    added = queue_transaction(hd, 20, IO_ONES);
    hd = random_slot();
    hd.kind = BURST_READ;
    added = queue_transaction(hd, 0, IO_ZEROS);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = idle_by_phase[ph];
      recv_stall_pct = stall_by_phase[ph];
      added = 0;
      while (added < ITEMS_PER_PHASE) begin
        hd = random_slot();
        hd.kind[KIND_BURST_BIT] = ($urandom_range(99) < 30);
        hd.kind[KIND_READ_BIT]  = 1'($urandom_range(1));
        added += queue_transaction(hd, ($urandom_range(3) == 0) ? 30 : 0,
                                   ($urandom_range(9) == 0) ?
                                   io_pattern_e'(1 + $urandom_range(1)) : IO_RANDOM);
        // idle slots between transactions, none most of the time
        repeat ($urandom_range(3) == 0 ? $urandom_range(1, 3) : 0) begin
          slot_item_q.push_back(random_slot());
          added++;
        end
      end
      // sender holds off until every outstanding result is back
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0 && slot_result_q.size() == 0) begin
      $display("three_wire_rtc_serial_master_unit verification clean");
    end else begin
      $display("three_wire_rtc_serial_master_unit verification failed");
    end
    $finish;
  end

endmodule
